// File: hw/rtl/mcf_pkg.sv
// Shared types, codes and helpers for the mesh corner finder.
package mcf_pkg;

	localparam int unsigned NODE_W  = 10;
	localparam int unsigned TOTAL_W = 11;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned CNT_W   = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FETCH = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CORNER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

	// Register select: the word address bit of the configuration port.
	localparam logic REG_NODE_COUNT  = 1'b0;
	localparam logic REG_CLEAN_EDGES = 1'b1;

	localparam logic [TOTAL_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Saturation point of the incidence counters.
	localparam logic [CNT_W-1:0] CORNER_MIN = 2'd3;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_CORNERS,
		PH_EDGES,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [NODE_W-1:0]  node_first;
		logic [NODE_W-1:0]  node_second;
		logic [TOTAL_W-1:0] corner_total;
		logic [TOTAL_W-1:0] edge_total;
		logic               last;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (c >= CORNER_MIN) ? c : c + CNT_W'(1);
		return r;
	endfunction

	function automatic result_t make_result(
		input logic [KIND_W-1:0]  kind,
		input logic [NODE_W-1:0]  first,
		input logic [NODE_W-1:0]  second,
		input logic [TOTAL_W-1:0] ctot,
		input logic [TOTAL_W-1:0] etot,
		input logic               last
	);
		result_t r;
		r.kind         = kind;
		r.node_first   = first;
		r.node_second  = second;
		r.corner_total = ctot;
		r.edge_total   = etot;
		r.last         = last;
		return r;
	endfunction

endpackage

// File: hw/rtl/mesh_corner_finder.sv
// Mesh corner finder: incidence-count memory, edge store and fetch sequencer.
// Add edge: accept, then a read-modify-write of each endpoint count (S_ADD_A, then S_ADD_B).
// Fetch: accept, then read and check each node (S_NODE_RD, S_NODE_CHK) and each stored edge
// (S_EDGE_RD, S_EDGE_CA, S_EDGE_CB, S_EDGE_CHK), close each finished pass and load the result register.
// Reset and clear both run a sweep over all MAX_NODES entries that zeroes the count memory; item_stall
// is high during the sweep while configuration writes are still taken.
module mesh_corner_finder #(
	parameter int unsigned MAX_NODES = 1024,
	parameter int unsigned MAX_EDGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [mcf_pkg::CMD_W-1:0]     cmd,
	input  logic [mcf_pkg::NODE_W-1:0]    node_a,
	input  logic [mcf_pkg::NODE_W-1:0]    node_b,

	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mcf_pkg::KIND_W-1:0]    kind,
	output logic [mcf_pkg::NODE_W-1:0]    node_first,
	output logic [mcf_pkg::NODE_W-1:0]    node_second,
	output logic [mcf_pkg::TOTAL_W-1:0]   corner_total,
	output logic [mcf_pkg::TOTAL_W-1:0]   edge_total,
	output logic                          last,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int unsigned NIDX_W = $clog2(MAX_NODES);
	localparam int unsigned NCNT_W = $clog2(MAX_NODES + 1);
	localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
	localparam int unsigned ECNT_W = $clog2(MAX_EDGES + 1);
	localparam int unsigned NODE_W = mcf_pkg::NODE_W;
	localparam int unsigned EDGE_W = 2 * mcf_pkg::NODE_W;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ADD_A,
		S_ADD_B,
		S_NODE_RD,
		S_NODE_CHK,
		S_EDGE_RD,
		S_EDGE_CA,
		S_EDGE_CB,
		S_EDGE_CHK,
		S_EMIT
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers. Writes decode the word address bit only;
	// reads return zero for addresses that are not word aligned.
	// ------------------------------------------------------------------
	logic [mcf_pkg::TOTAL_W-1:0] node_count_q;
	logic                        clean_edges_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= mcf_pkg::NODE_COUNT_RST;
			clean_edges_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				mcf_pkg::REG_NODE_COUNT:  node_count_q  <= pwdata[mcf_pkg::TOTAL_W-1:0];
				mcf_pkg::REG_CLEAN_EDGES: clean_edges_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				mcf_pkg::REG_NODE_COUNT:  prdata = 32'(node_count_q);
				mcf_pkg::REG_CLEAN_EDGES: prdata = 32'(clean_edges_q);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Control state.
	// ------------------------------------------------------------------
	state_t                    state_q;
	mcf_pkg::phase_t           phase_q;
	logic [NIDX_W-1:0]         clr_q;
	logic [ECNT_W-1:0]         stored_q;
	logic [NCNT_W-1:0]         nscan_q;
	logic [ECNT_W-1:0]         escan_q;
	logic [NCNT_W-1:0]         corners_q;
	logic [ECNT_W-1:0]         kept_q;
	logic [NODE_W-1:0]         node_a_q;
	logic [NODE_W-1:0]         node_b_q;
	logic [mcf_pkg::CNT_W-1:0] bump_q;
	logic                      corner_a_q;
	mcf_pkg::result_t          res_q;
	mcf_pkg::result_t          out_q;
	logic                      result_valid_q;

	// ------------------------------------------------------------------
	// Memories. The count memory holds one saturating 2-bit incidence
	// count per node; the edge store holds both endpoints of each edge in
	// arrival order. Both memories have registered reads.
	// ------------------------------------------------------------------
	logic [mcf_pkg::CNT_W-1:0] cnt_mem [MAX_NODES];
	logic [mcf_pkg::CNT_W-1:0] cnt_rd_q;
	logic [NIDX_W-1:0]         cnt_raddr;
	logic                      cnt_we;
	logic [NIDX_W-1:0]         cnt_waddr;
	logic [mcf_pkg::CNT_W-1:0] cnt_wdata;

	logic [EDGE_W-1:0]         edge_mem [MAX_EDGES];
	logic [EDGE_W-1:0]         edge_rd_q;
	logic                      edge_re;
	logic [EIDX_W-1:0]         edge_raddr;
	logic                      edge_we;
	logic [EIDX_W-1:0]         edge_waddr;
	logic [EDGE_W-1:0]         edge_wdata;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_waddr] <= edge_wdata;
		end
		if (edge_re) begin
			edge_rd_q <= edge_mem[edge_raddr];
		end
	end

	// ------------------------------------------------------------------
	// Decode of the current transaction and shared terms.
	// ------------------------------------------------------------------
	logic [NCNT_W-1:0]         bound;
	logic                      item_acc;
	logic                      out_free;
	logic                      add_err;
	logic [mcf_pkg::CNT_W-1:0] cnt_b_fwd;
	logic                      rd_corner;
	logic [NODE_W-1:0]         edge_a;
	logic [NODE_W-1:0]         edge_b;
	logic [ECNT_W-1:0]         done_edges;

	// The node bound is the smaller of the register and the memory depth.
	always_comb begin
		if (32'(node_count_q) < MAX_NODES) begin
			bound = NCNT_W'(node_count_q);
		end else begin
			bound = NCNT_W'(MAX_NODES);
		end
	end

	// The block works on one transaction at a time; the result register
	// lets a new item in while the previous result still waits.
	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	// An edge is refused once fetching has begun, when the store is full
	// or when an endpoint lies outside the node bound.
	assign add_err = (phase_q != mcf_pkg::PH_LOAD)
		|| (32'(stored_q) >= MAX_EDGES)
		|| (32'(node_a) >= 32'(bound))
		|| (32'(node_b) >= 32'(bound));

	// The second endpoint's count is read in the same cycle as the first
	// endpoint is written back, so a self-loop takes the fresh value.
	assign cnt_b_fwd = (node_b_q == node_a_q) ? bump_q : cnt_rd_q;
	assign rd_corner = (cnt_rd_q >= mcf_pkg::CORNER_MIN);

	assign edge_a = edge_rd_q[EDGE_W-1 -: NODE_W];
	assign edge_b = edge_rd_q[NODE_W-1:0];

	// A repeated summary reports kept edges once the edge pass has run,
	// and the stored edge count otherwise.
	assign done_edges = ((escan_q != '0) || (kept_q != '0)) ? kept_q : stored_q;

	// ------------------------------------------------------------------
	// Memory port control.
	// ------------------------------------------------------------------
	always_comb begin
		cnt_raddr  = '0;
		cnt_we     = 1'b0;
		cnt_waddr  = '0;
		cnt_wdata  = '0;
		edge_re    = 1'b0;
		edge_raddr = '0;
		edge_we    = 1'b0;
		edge_waddr = EIDX_W'(stored_q);
		edge_wdata = {node_a, node_b};
		case (state_q)
			S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
			end
			S_IDLE: begin
				// Start the first endpoint's read in the accept cycle.
				cnt_raddr = NIDX_W'(node_a);
				edge_we   = item_acc && (cmd == mcf_pkg::CMD_ADD) && !add_err;
			end
			S_ADD_A: begin
				cnt_we    = 1'b1;
				cnt_waddr = NIDX_W'(node_a_q);
				cnt_wdata = mcf_pkg::sat_inc(cnt_rd_q);
				cnt_raddr = NIDX_W'(node_b_q);
			end
			S_ADD_B: begin
				cnt_we    = 1'b1;
				cnt_waddr = NIDX_W'(node_b_q);
				cnt_wdata = mcf_pkg::sat_inc(cnt_b_fwd);
			end
			S_NODE_RD: begin
				cnt_raddr = nscan_q[NIDX_W-1:0];
			end
			S_EDGE_RD: begin
				edge_re    = 1'b1;
				edge_raddr = escan_q[EIDX_W-1:0];
			end
			S_EDGE_CA: begin
				cnt_raddr = NIDX_W'(edge_a);
			end
			S_EDGE_CB: begin
				cnt_raddr = NIDX_W'(edge_b);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			phase_q        <= mcf_pkg::PH_LOAD;
			clr_q          <= '0;
			stored_q       <= '0;
			nscan_q        <= '0;
			escan_q        <= '0;
			corners_q      <= '0;
			kept_q         <= '0;
			node_a_q       <= '0;
			node_b_q       <= '0;
			bump_q         <= '0;
			corner_a_q     <= 1'b0;
			res_q          <= '0;
			out_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// The emit state reloads the output register itself.
			if (result_valid_q && !result_stall && (state_q != S_EMIT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					// One count entry cleared per cycle.
					if (clr_q == NIDX_W'(MAX_NODES - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + NIDX_W'(1);
					end
				end
				S_IDLE: begin
					if (item_acc) begin
						case (cmd)
							mcf_pkg::CMD_CLEAR: begin
								state_q   <= S_CLR;
								clr_q     <= '0;
								phase_q   <= mcf_pkg::PH_LOAD;
								stored_q  <= '0;
								nscan_q   <= '0;
								escan_q   <= '0;
								corners_q <= '0;
								kept_q    <= '0;
							end
							mcf_pkg::CMD_ADD: begin
								if (add_err) begin
									res_q <= mcf_pkg::make_result(mcf_pkg::KIND_ERROR,
										'0, '0, '0, '0, 1'b0);
									state_q <= S_EMIT;
								end else begin
									stored_q <= stored_q + ECNT_W'(1);
									node_a_q <= node_a;
									node_b_q <= node_b;
									state_q  <= S_ADD_A;
								end
							end
							mcf_pkg::CMD_FETCH: begin
								case (phase_q)
									mcf_pkg::PH_LOAD, mcf_pkg::PH_CORNERS: begin
										phase_q <= mcf_pkg::PH_CORNERS;
										state_q <= S_NODE_RD;
									end
									mcf_pkg::PH_EDGES: begin
										state_q <= S_EDGE_RD;
									end
									default: begin
										res_q <= mcf_pkg::make_result(mcf_pkg::KIND_DONE,
											'0, '0, mcf_pkg::TOTAL_W'(corners_q),
											mcf_pkg::TOTAL_W'(done_edges), 1'b1);
										state_q <= S_EMIT;
									end
								endcase
							end
							default: ;
						endcase
					end
				end
				S_ADD_A: begin
					bump_q  <= mcf_pkg::sat_inc(cnt_rd_q);
					state_q <= S_ADD_B;
				end
				S_ADD_B: begin
					state_q <= S_IDLE;
				end
				S_NODE_RD: begin
					if (nscan_q < bound) begin
						state_q <= S_NODE_CHK;
					end else if (clean_edges_q) begin
						// Corner pass over: go on with the edge pass in
						// the same fetch.
						phase_q <= mcf_pkg::PH_EDGES;
						state_q <= S_EDGE_RD;
					end else begin
						phase_q <= mcf_pkg::PH_DONE;
						res_q   <= mcf_pkg::make_result(mcf_pkg::KIND_DONE, '0, '0,
							mcf_pkg::TOTAL_W'(corners_q), mcf_pkg::TOTAL_W'(stored_q), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_NODE_CHK: begin
					nscan_q <= nscan_q + NCNT_W'(1);
					if (rd_corner) begin
						corners_q <= corners_q + NCNT_W'(1);
						res_q     <= mcf_pkg::make_result(mcf_pkg::KIND_CORNER,
							NODE_W'(nscan_q), '0, '0, '0, 1'b0);
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_NODE_RD;
					end
				end
				S_EDGE_RD: begin
					if (escan_q < stored_q) begin
						state_q <= S_EDGE_CA;
					end else begin
						phase_q <= mcf_pkg::PH_DONE;
						res_q   <= mcf_pkg::make_result(mcf_pkg::KIND_DONE, '0, '0,
							mcf_pkg::TOTAL_W'(corners_q), mcf_pkg::TOTAL_W'(kept_q), 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_EDGE_CA: begin
					state_q <= S_EDGE_CB;
				end
				S_EDGE_CB: begin
					corner_a_q <= rd_corner;
					state_q    <= S_EDGE_CHK;
				end
				S_EDGE_CHK: begin
					escan_q <= escan_q + ECNT_W'(1);
					if (!corner_a_q && !rd_corner) begin
						kept_q  <= kept_q + ECNT_W'(1);
						res_q   <= mcf_pkg::make_result(mcf_pkg::KIND_EDGE,
							edge_a, edge_b, '0, '0, 1'b0);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_EDGE_RD;
					end
				end
				S_EMIT: begin
					// Hand the result over once the output register is free.
					if (out_free) begin
						out_q          <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = out_q.kind;
	assign node_first   = out_q.node_first;
	assign node_second  = out_q.node_second;
	assign corner_total = out_q.corner_total;
	assign edge_total   = out_q.edge_total;
	assign last         = out_q.last;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// Only the summary transaction carries the last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (kind == mcf_pkg::KIND_DONE)))
		else $error("last flag does not match the summary kind");

	// An accepted clear always starts the count sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && (cmd == mcf_pkg::CMD_CLEAR)) |=> (state_q == S_CLR))
		else $error("clear did not start the count sweep");

	// The edge store never holds more edges than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(stored_q) <= MAX_EDGES))
		else $error("edge store overfilled");

	// No new result appears while the count memory is being swept.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |=> !$rose(result_valid_q))
		else $error("result produced during the clearing sweep");

endmodule
